### sv/b3i_pkg.sv
`timescale 1ns / 1ps
package b3i_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_WRITE,
    S_VOL,
    S_READ,
    S_OVL,
    S_DIV,
    S_FIN
  } state_t;

  // Which product the shared three-factor sequence is forming.
  typedef enum logic [1:0] {
    VSEL_QUERY,
    VSEL_INTER,
    VSEL_SLOT
  } vsel_t;

  localparam logic REG_ENTRY_COUNT = 1'b0;
  localparam logic REG_MIN_IOU     = 1'b1;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [16:0] MIN_IOU_RESET = 17'd19661;
  localparam int          ENTRY_W       = 6 * 32;

  // Scaled size from a 24x16 product: drop 8 fraction bits, saturate to Q16.16.
  function automatic logic [31:0] scale_sat(input logic [63:0] p);
    logic [31:0] r;
    if (p[39]) begin
      r = 32'h7FFF_FFFF;
    end else begin
      r = {1'b0, p[38:8]};
    end
    return r;
  endfunction

  // Open overlap along one axis in doubled units; zero when intervals do not meet.
  function automatic logic [31:0] axis_ovl(input logic signed [31:0] c1,
                                           input logic [31:0] s1,
                                           input logic signed [31:0] c2,
                                           input logic [31:0] s2);
    logic signed [35:0] lo1, hi1, lo2, hi2, lo, hi, d;
    logic [31:0] r;
    lo1 = 36'(c1) * 36'sd2 - $signed({4'b0, s1});
    hi1 = 36'(c1) * 36'sd2 + $signed({4'b0, s1});
    lo2 = 36'(c2) * 36'sd2 - $signed({4'b0, s2});
    hi2 = 36'(c2) * 36'sd2 + $signed({4'b0, s2});
    lo = (lo1 > lo2) ? lo1 : lo2;
    hi = (hi1 < hi2) ? hi1 : hi2;
    d = hi - lo;
    if (lo >= hi) begin
      r = 32'd0;
    end else begin
      r = d[31:0];
    end
    return r;
  endfunction

endpackage

### sv/b3i_ram.sv
`timescale 1ns / 1ps
module b3i_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/b3i_div.sv
`timescale 1ns / 1ps
module b3i_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [95:0] num,
  input  logic [96:0] den,
  output logic        done,
  output logic [16:0] quo
);

  // Restoring division, one quotient bit per cycle, 17 bits in all.
  logic [97:0] rem;
  logic [96:0] dreg;
  logic [4:0]  cnt;
  logic        busy;
  logic [97:0] rs;
  logic        ge;

  always_comb begin
    rs = (cnt == 5'd0) ? rem : {rem[96:0], 1'b0};
    ge = rs >= {1'b0, dreg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd16) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {2'b0, num};
      dreg <= den;
      quo  <= 17'd0;
    end else if (busy) begin
      rem <= ge ? (rs - {1'b0, dreg}) : rs;
      quo <= {quo[15:0], ge};
    end
  end

endmodule

### sv/box3d_iou_best_match_unit.sv
`timescale 1ns / 1ps
// Best-match unit for axis-aligned 3D boxes. A load transfer (tuser = 0) scales the sizes and
// stores center and scaled size in one table slot; it returns nothing. A query transfer
// (tuser = 1) scales its own sizes, forms its volume, then walks the slots below entry_count
// (at most MAX_BOXES), reading one table entry at a time from a single-port-read RAM. A slot
// whose boxes do not overlap goes on to the next slot after the overlap test; an overlapping one
// takes two three-factor products on the one shared 32x32 multiplier, then the divider for the
// Q1.16 IoU. One item is in work at a time; the result sits in an output register so the next
// item can be taken while the result waits for its transfer.
module box3d_iou_best_match_unit
  import b3i_pkg::*;
#(
  parameter int MAX_BOXES = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // slot[3:0], center_x[35:4], center_y[67:36], center_z[99:68], extent_x[123:100],
  // extent_y[147:124], extent_z[171:148], size_scale[187:172], zero fill above
  input  logic [191:0]  s_tdata,
  // mode
  input  logic          s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  // best_iou[16:0], best_slot[20:17], zero fill above
  output logic [23:0]   m_tdata,
  // is_new
  output logic          m_tuser,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);

  // Configuration registers.
  logic [4:0]  entry_count;
  logic [16:0] min_iou;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MIN_IOU) ? {15'd0, min_iou} : {27'd0, entry_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= 5'd0;
      min_iou     <= MIN_IOU_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_ENTRY_COUNT) begin
        entry_count <= pwdata[4:0];
      end else begin
        min_iou <= pwdata[16:0];
      end
    end
  end

  state_t state, state_next;
  vsel_t  vsel;
  logic [1:0] cnt;

  // Captured input item.
  logic               mode;
  logic [3:0]         slot;
  logic signed [31:0] cx, cy, cz;
  logic [23:0]        ex, ey, ez;
  logic [15:0]        scl;

  logic [31:0] sx, sy, sz;
  logic [31:0] opa, opb, opc;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [31:0] sc_prod;
  logic [31:0] phi;
  logic [63:0] plo;
  logic [95:0] vol_res;
  logic [95:0] vq, inter;

  logic [CW-1:0] k, n;
  logic          last_slot;
  logic [16:0]   best;
  logic [IW-1:0] best_k;

  logic [ENTRY_W-1:0] rdata, wdata;
  logic               ram_we;
  logic               slot_ok;

  logic [31:0] ovx, ovy, ovz;
  logic        hit;

  logic        div_start, div_done;
  logic [16:0] div_q;
  logic [96:0] uni;

  logic out_free;

  assign s_tready  = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign last_slot = (k + CW'(1)) == n;
  assign slot_ok   = {5'd0, slot} < 9'(MAX_BOXES);
  assign sc_prod   = scale_sat(prod);

  // Stored entry: center x, y, z then scaled size x, y, z from the low bits up.
  assign wdata = {sz, sy, sx, cz, cy, cx};

  always_comb begin
    ovx = axis_ovl(cx, sx, rdata[31:0], rdata[127:96]);
    ovy = axis_ovl(cy, sy, rdata[63:32], rdata[159:128]);
    ovz = axis_ovl(cz, sz, rdata[95:64], rdata[191:160]);
    hit = (ovx != 32'd0) && (ovy != 32'd0) && (ovz != 32'd0);
    vol_res = {prod, 32'd0} + {32'd0, plo};
    uni = ({1'b0, vq} + {1'b0, vol_res}) - {1'b0, inter};
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        if (cnt == 2'd3) begin
          state_next = (mode == MODE_LOAD) ? S_WRITE : S_VOL;
        end
      end
      S_WRITE: state_next = S_IDLE;
      S_VOL: begin
        if (cnt == 2'd3) begin
          case (vsel)
            VSEL_QUERY: state_next = (n == CW'(0)) ? S_FIN : S_READ;
            VSEL_INTER: state_next = S_VOL;
            default:    state_next = S_DIV;
          endcase
        end
      end
      S_READ: state_next = S_OVL;
      S_OVL: begin
        if (hit) begin
          state_next = S_VOL;
        end else begin
          state_next = last_slot ? S_FIN : S_READ;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = last_slot ? S_FIN : S_READ;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs: multiplier operands, table write, divider start.
  always_comb begin
    mul_a     = opa;
    mul_b     = opb;
    ram_we    = 1'b0;
    div_start = 1'b0;
    case (state)
      S_SCALE: begin
        mul_b = {16'd0, scl};
        case (cnt)
          2'd0:    mul_a = {8'd0, ex};
          2'd1:    mul_a = {8'd0, ey};
          default: mul_a = {8'd0, ez};
        endcase
      end
      S_VOL: begin
        case (cnt)
          2'd0: begin
            mul_a = opa;
            mul_b = opb;
          end
          2'd1: begin
            mul_a = prod[31:0];
            mul_b = opc;
          end
          default: begin
            mul_a = phi;
            mul_b = opc;
          end
        endcase
        div_start = (cnt == 2'd3) && (vsel == VSEL_SLOT);
      end
      S_WRITE: ram_we = slot_ok;
      default: begin
        mul_a = opa;
        mul_b = opb;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= 2'd0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SCALE || state == S_VOL) begin
        cnt <= cnt + 2'd1;
      end else begin
        cnt <= 2'd0;
      end
      if (state == S_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          mode <= s_tuser;
          slot <= s_tdata[3:0];
          cx   <= s_tdata[35:4];
          cy   <= s_tdata[67:36];
          cz   <= s_tdata[99:68];
          ex   <= s_tdata[123:100];
          ey   <= s_tdata[147:124];
          ez   <= s_tdata[171:148];
          scl  <= s_tdata[187:172];
        end
      end
      S_SCALE: begin
        case (cnt)
          2'd1: sx <= sc_prod;
          2'd2: sy <= sc_prod;
          2'd3: begin
            sz   <= sc_prod;
            opa  <= {sx[30:0], 1'b0};
            opb  <= {sy[30:0], 1'b0};
            opc  <= {sc_prod[30:0], 1'b0};
            vsel <= VSEL_QUERY;
            n    <= ({4'd0, entry_count} > 9'(MAX_BOXES)) ? CW'(MAX_BOXES)
                                                          : CW'(entry_count);
            k      <= CW'(0);
            best   <= 17'd0;
            best_k <= IW'(0);
          end
          default: ;
        endcase
      end
      S_VOL: begin
        case (cnt)
          2'd1: phi <= prod[63:32];
          2'd2: plo <= prod;
          2'd3: begin
            case (vsel)
              VSEL_QUERY: vq <= vol_res;
              VSEL_INTER: begin
                inter <= vol_res;
                opa   <= {rdata[126:96], 1'b0};
                opb   <= {rdata[158:128], 1'b0};
                opc   <= {rdata[190:160], 1'b0};
                vsel  <= VSEL_SLOT;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      S_OVL: begin
        if (hit) begin
          opa  <= ovx;
          opb  <= ovy;
          opc  <= ovz;
          vsel <= VSEL_INTER;
        end else if (!last_slot) begin
          k <= k + CW'(1);
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (div_q > best) begin
            best   <= div_q;
            best_k <= k[IW-1:0];
          end
          if (!last_slot) begin
            k <= k + CW'(1);
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          m_tdata[16:0]  <= best;
          m_tdata[23:21] <= 3'd0;
          if (best < min_iou) begin
            m_tdata[20:17] <= 4'd0;
            m_tuser        <= 1'b1;
          end else begin
            m_tdata[20:17] <= 4'(best_k);
            m_tuser        <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  b3i_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_BOXES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(IW'(slot)),
    .wdata(wdata),
    .raddr(k[IW-1:0]),
    .rdata(rdata)
  );

  b3i_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (inter),
    .den  (uni),
    .done (div_done),
    .quo  (div_q)
  );

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_tready)
    else $error("input ready outside idle");

  a_new_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[20:17] == 4'd0))
    else $error("new box reported with nonzero slot");

  a_iou_range: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (div_q <= 17'd65536))
    else $error("IoU above one");

  a_no_write_in_query: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (mode == MODE_LOAD))
    else $error("table written during a query");

endmodule

### verif/box3d_iou_match_checker.sv
`timescale 1ns / 1ps
// Watches the input, result and register channels of the best-match unit, keeps its own copy of
// the box table and the registers, predicts each query result and compares it field by field.
module box3d_iou_match_checker
  import b3i_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [191:0] s_tdata,
  input  logic         s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [23:0]  m_tdata,
  input  logic         m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic         pready,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output int           mismatches,
  output int           awaiting
);

  typedef struct {
    logic [16:0] iou;
    logic [3:0]  slot;
    logic        fresh;
  } match_t;

  match_t      match_q[$];
  logic [31:0] tab_cx[16], tab_cy[16], tab_cz[16];
  logic [31:0] tab_sx[16], tab_sy[16], tab_sz[16];
  logic [4:0]  count_reg;
  logic [16:0] thresh_reg;

  function automatic logic [31:0] scaled(input logic [23:0] ext, input logic [15:0] sc);
    logic [39:0] p;
    p = {16'b0, ext} * {24'b0, sc};
    p = p >> 8;
    return (p > 40'h7FFF_FFFF) ? 32'h7FFF_FFFF : p[31:0];
  endfunction

  // Open overlap in doubled units; touching faces give zero.
  function automatic logic [63:0] span(input logic [31:0] c1, input logic [31:0] s1,
                                       input logic [31:0] c2, input logic [31:0] s2);
    longint lo1, hi1, lo2, hi2, lo, hi;
    lo1 = 2 * longint'($signed(c1)) - $signed({32'b0, s1});
    hi1 = 2 * longint'($signed(c1)) + $signed({32'b0, s1});
    lo2 = 2 * longint'($signed(c2)) - $signed({32'b0, s2});
    hi2 = 2 * longint'($signed(c2)) + $signed({32'b0, s2});
    lo = (lo1 > lo2) ? lo1 : lo2;
    hi = (hi1 < hi2) ? hi1 : hi2;
    return (lo >= hi) ? 64'd0 : 64'(hi - lo);
  endfunction

  function automatic logic [127:0] vol(input logic [31:0] a, input logic [31:0] b,
                                       input logic [31:0] c);
    return ({96'b0, a} * 2) * ({96'b0, b} * 2) * ({96'b0, c} * 2);
  endfunction

  function automatic match_t best_match(input logic [191:0] d);
    match_t      r;
    logic [31:0] sx, sy, sz;
    logic [63:0] ox, oy, oz;
    logic [127:0] vq, inter, uni, q;
    logic [16:0] best;
    logic [3:0]  best_k;
    int          n;
    sx = scaled(d[123:100], d[187:172]);
    sy = scaled(d[147:124], d[187:172]);
    sz = scaled(d[171:148], d[187:172]);
    vq = vol(sx, sy, sz);
    n = (count_reg > 16) ? 16 : count_reg;
    best = 0;
    best_k = 0;
    for (int k = 0; k < n; k++) begin
      ox = span(d[35:4], sx, tab_cx[k], tab_sx[k]);
      oy = span(d[67:36], sy, tab_cy[k], tab_sy[k]);
      oz = span(d[99:68], sz, tab_cz[k], tab_sz[k]);
      if (ox != 0 && oy != 0 && oz != 0) begin
        inter = {64'b0, ox} * {64'b0, oy} * {64'b0, oz};
        uni = vq + vol(tab_sx[k], tab_sy[k], tab_sz[k]) - inter;
        q = (inter << 16) / uni;
        if (q[16:0] > best) begin
          best = q[16:0];
          best_k = 4'(k);
        end
      end
    end
    r.iou = best;
    r.fresh = (best < thresh_reg);
    r.slot = r.fresh ? 4'd0 : best_k;
    return r;
  endfunction

  always @(posedge clk) begin
    match_t e;
    logic [3:0] s;
    if (rst) begin
      count_reg = 0;
      thresh_reg = MIN_IOU_RESET;
      mismatches = 0;
      match_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_ENTRY_COUNT: count_reg = pwdata[4:0];
          REG_MIN_IOU:     thresh_reg = pwdata[16:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == MODE_LOAD) begin
          s = s_tdata[3:0];
          tab_cx[s] = s_tdata[35:4];
          tab_cy[s] = s_tdata[67:36];
          tab_cz[s] = s_tdata[99:68];
          tab_sx[s] = scaled(s_tdata[123:100], s_tdata[187:172]);
          tab_sy[s] = scaled(s_tdata[147:124], s_tdata[187:172]);
          tab_sz[s] = scaled(s_tdata[171:148], s_tdata[187:172]);
        end else begin
          match_q = {match_q, best_match(s_tdata)};
        end
      end
      if (m_tvalid && m_tready) begin
        if (match_q.size() == 0) begin
          $error("result transfer with no query outstanding");
          mismatches++;
        end else begin
          e = match_q.pop_front();
          if (m_tdata[16:0] !== e.iou) begin
            $error("best_iou: expected %0d, got %0d", e.iou, m_tdata[16:0]);
            mismatches++;
          end
          if (m_tdata[20:17] !== e.slot) begin
            $error("best_slot: expected %0d, got %0d", e.slot, m_tdata[20:17]);
            mismatches++;
          end
          if (m_tuser !== e.fresh) begin
            $error("is_new: expected %0d, got %0d", e.fresh, m_tuser);
            mismatches++;
          end
        end
      end
    end
    awaiting = match_q.size();
  end

endmodule

### verif/box3d_iou_best_match_unit_tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the best-match unit. The checker beside the block does all of the
// prediction; this module fills the table, sweeps the registers through a series of settings
// and feeds loads and queries, most of them placed close to stored boxes so that overlaps occur.
module box3d_iou_best_match_unit_tb;
  import b3i_pkg::*;

  localparam int LIMIT_CYCLES = 4_000_000;
  // A load leaves no result to wait for, so this settling time covers loads as well as queries.
  localparam int SETTLE = 600;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 116;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [191:0] s_tdata = '0;
  logic         s_tuser = 0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [23:0]  m_tdata;
  logic         m_tuser;
  logic         psel = 0;
  logic         penable = 0;
  logic         pwrite = 0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  int  mismatches;
  int  awaiting;
  int  cycles = 0;
  bit  stall_on = 1;

  // Stimulus-side copy of what each slot was loaded with, used to aim queries.
  logic [31:0] aim_cx[16], aim_cy[16], aim_cz[16];
  logic [23:0] aim_ex[16], aim_ey[16], aim_ez[16];

  box3d_iou_best_match_unit dut (.*);

  box3d_iou_match_checker chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .m_tvalid, .m_tready, .m_tdata,
    .m_tuser, .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .mismatches, .awaiting
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("box3d_iou_best_match_unit regression: fail");
      $finish;
    end
  end

  // The receiver stalls with a probability of about 30 percent unless stalls are switched off.
  always @(posedge clk) begin
    m_tready <= stall_on ? ($urandom_range(99) >= 30) : 1'b1;
  end

  task automatic reg_write(input logic idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  // Holds valid until the transfer completes; valid stays high for a back-to-back item.
  task automatic send(input logic mode, input logic [3:0] slot, input logic [31:0] cx,
                      input logic [31:0] cy, input logic [31:0] cz, input logic [23:0] ex,
                      input logic [23:0] ey, input logic [23:0] ez, input logic [15:0] sc);
    while (stall_on && $urandom_range(99) < 30) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= mode;
    s_tdata <= {4'b0, sc, ez, ey, ex, cz, cy, cx, slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (mode == MODE_LOAD) begin
      aim_cx[slot] = cx;
      aim_cy[slot] = cy;
      aim_cz[slot] = cz;
      aim_ex[slot] = ex;
      aim_ey[slot] = ey;
      aim_ez[slot] = ez;
    end
  endtask

  // Lets the block drain completely so that registers may be rewritten.
  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] near(input logic [31:0] c);
    return c + 32'($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
  endfunction

  function automatic logic [23:0] wobble(input logic [23:0] e);
    return e + 24'($urandom_range(0, 32'h1_0000)) - 24'h8000;
  endfunction

  function automatic logic [31:0] rand_center();
    return 32'($urandom_range(0, 32'h10_0000)) - 32'h8_0000;
  endfunction

  logic [4:0]  count_set[PHASES] = '{5'd16, 5'd1, 5'd8, 5'd0, 5'd16, 5'd31, 5'd3, 5'd12,
                                     5'd16, 5'd5, 5'd16, 5'd16};
  logic [16:0] thresh_set[PHASES] = '{17'd0, 17'd65536, 17'd19661, 17'd100000, 17'd32768,
                                      17'd1, 17'd0, 17'd131071, 17'd40000, 17'd65535,
                                      17'd10000, 17'd19661};

  initial begin
    int pick;
    logic [3:0] j;
    logic [23:0] e;
    repeat (6) @(posedge clk);
    rst <= 0;

    // Directed: every slot loaded before any slot takes part in a query.
    for (int k = 0; k < 14; k++) begin
      e = 24'h1_0000 + 24'(k) * 24'h4000;
      send(MODE_LOAD, 4'(k), 32'(k) * 32'h3_0000, 32'h1_0000, 32'hFFFF_0000, e, e, e, 16'h0100);
    end
    // Slot 1 repeats slot 0 so that a query on it ties and the lower slot wins.
    send(MODE_LOAD, 4'd1, 32'h0, 32'h1_0000, 32'hFFFF_0000, 24'h1_0000, 24'h1_0000,
         24'h1_0000, 16'h0100);
    // Zero-size box at the most negative center.
    send(MODE_LOAD, 4'd14, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'h0, 24'h0, 24'h0,
         16'hFFFF);
    // Saturated sizes at the most positive center.
    send(MODE_LOAD, 4'd15, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF,
         24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF);
    // With the reset count of zero nothing takes part.
    send(MODE_QUERY, 4'hF, 32'h0, 32'h1_0000, 32'hFFFF_0000, 24'h1_0000, 24'h1_0000,
         24'h1_0000, 16'h0100);
    drain();
    reg_write(REG_ENTRY_COUNT, 32'd16);
    reg_write(REG_MIN_IOU, 32'(MIN_IOU_RESET));
    // Exact match with a tie between slots 0 and 1.
    send(MODE_QUERY, 4'h0, 32'h0, 32'h1_0000, 32'hFFFF_0000, 24'h1_0000, 24'h1_0000,
         24'h1_0000, 16'h0100);
    // Query box lies wholly inside slot 6.
    send(MODE_QUERY, 4'h0, 32'h10_0000 + 32'h1_4000 + 32'h8000, 32'h1_0000, 32'hFFFF_0000,
         24'h1_0000, 24'h1_0000, 24'h1_0000, 16'h0100);
    // Zero-size query inside slot 2.
    send(MODE_QUERY, 4'h0, 32'h6_0000, 32'h1_0000, 32'hFFFF_0000, 24'h1_0000, 24'h1_0000,
         24'h1_0000, 16'h0000);
    // Far from everything.
    send(MODE_QUERY, 4'h0, 32'h4000_0000, 32'hC000_0000, 32'h4000_0000, 24'h1_0000,
         24'h1_0000, 24'h1_0000, 16'h0100);
    // A query whose sizes scale to zero at the center of slot 15, so it has no overlap and an IoU of zero.
    send(MODE_QUERY, 4'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'h1, 24'h1, 24'h1,
         16'h0001);
    // Largest query box around slot 15.
    send(MODE_QUERY, 4'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF,
         24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      reg_write(REG_ENTRY_COUNT, 32'(count_set[p]));
      reg_write(REG_MIN_IOU, 32'(thresh_set[p]));
      stall_on = (p != 4);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(99);
        j = 4'($urandom_range(0, 13));
        if (pick < 10) begin
          // Noise: every field drawn over its whole range.
          send(1'($urandom), 4'($urandom), $urandom, $urandom, $urandom, 24'($urandom),
               24'($urandom), 24'($urandom), 16'($urandom));
        end else if (pick < 30) begin
          e = 24'($urandom_range(1, 32'h4_0000));
          send(MODE_LOAD, j, rand_center(), rand_center(), rand_center(), e,
               24'($urandom_range(1, 32'h4_0000)), 24'($urandom_range(1, 32'h4_0000)),
               16'($urandom_range(32'h80, 32'h200)));
        end else begin
          send(MODE_QUERY, 4'($urandom), near(aim_cx[j]), near(aim_cy[j]), near(aim_cz[j]),
               wobble(aim_ex[j]), wobble(aim_ey[j]), wobble(aim_ez[j]),
               16'($urandom_range(32'hF0, 32'h110)));
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("box3d_iou_best_match_unit regression: pass");
    end else begin
      $display("box3d_iou_best_match_unit regression: fail");
    end
    $finish;
  end

endmodule

### files.f
sv/b3i_pkg.sv
sv/b3i_ram.sv
sv/b3i_div.sv
sv/box3d_iou_best_match_unit.sv
verif/box3d_iou_match_checker.sv
verif/box3d_iou_best_match_unit_tb.sv
